[design/assert_macros.svh]
// Assertion macros shared by the vector search RTL.
// Included by modules that check their own control logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define CTK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Checks that a trigger is followed in the next cycle by a consequence.
`define CTK_ASSERT_NEXT(lbl, clk, rstn, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/ctk_pkg.sv]
// Shared types and constants of the cosine top-k vector search.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ctk_pkg;

    localparam int SCORE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP_K = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM   = 2'd1;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ADDED = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_MATCH = 2'd2,
        STATUS_EMPTY = 2'd3
    } ctk_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DOT,
        ST_SCORE,
        ST_EMIT
    } ctk_state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_PREP,
        SC_SRCH
    } ctk_sc_state_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } ctk_cell_ctrl_t;

endpackage

[design/ctk_score.sv]
// Iterative cosine score unit: shift-add products, then a bit-serial root search.
// Depends on ctk_pkg.
`timescale 1ns / 1ps

module ctk_score import ctk_pkg::*; #(
    parameter int DW = 39,
    parameter int NW = 38
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [DW-1:0]      dot,
    input  logic        [NW-1:0]      norm_q,
    input  logic        [NW-1:0]      norm_d,
    output logic                      done,
    output logic signed [SCORE_W-1:0] score
);

    localparam int WW = 2 * DW + 32;
    localparam int CW = $clog2(DW);

    ctk_sc_state_t st_reg, st_next;

    logic              neg_reg;
    logic [CW-1:0]     cnt_reg;
    logic [NW-1:0]     ay_reg;
    logic [DW-1:0]     ax_reg;
    logic [WW-1:0]     by_reg, bx_reg, yacc_reg, xacc_reg;
    logic [WW-1:0]     p_reg, r_reg, yb_reg;
    logic [15:0]       m_reg;
    logic              done_reg;
    logic signed [SCORE_W-1:0] score_reg;

    logic [DW-1:0] mag;
    logic [WW-1:0] trial, x_val;
    logic          take;
    logic [15:0]   m_new;
    logic [16:0]   m_wide, mag_c, neg_c;
    logic signed [SCORE_W-1:0] score_fin;

    always_comb begin
        mag    = dot[DW-1] ? DW'(-dot) : DW'(dot);
        x_val  = xacc_reg << 30;
        trial  = p_reg + r_reg + yb_reg;
        take   = (trial <= x_val);
        m_new  = take ? (m_reg | (16'h8000 >> cnt_reg)) : m_reg;
        m_wide = {1'b0, m_new};
        mag_c  = (m_wide > 17'd32768) ? 17'd32768 : m_wide;
        neg_c  = 17'd0 - mag_c;
        if (neg_reg) begin
            score_fin = signed'(neg_c[15:0]);
        end else if (mag_c > 17'd32767) begin
            score_fin = 16'sd32767;
        end else begin
            score_fin = signed'(mag_c[15:0]);
        end
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            SC_IDLE: begin
                if (start && norm_q != '0 && norm_d != '0) begin
                    st_next = SC_MUL;
                end
            end
            SC_MUL: begin
                if (cnt_reg == CW'(DW - 1)) begin
                    st_next = SC_PREP;
                end
            end
            SC_PREP: st_next = SC_SRCH;
            SC_SRCH: begin
                if (cnt_reg == CW'(15)) begin
                    st_next = SC_IDLE;
                end
            end
            default: st_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= SC_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= 1'b0;
            if (st_reg == SC_IDLE && start && (norm_q == '0 || norm_d == '0)) begin
                done_reg <= 1'b1;
            end
            if (st_reg == SC_SRCH && cnt_reg == CW'(15)) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (st_reg)
            SC_IDLE: begin
                neg_reg   <= dot[DW-1];
                ay_reg    <= norm_q;
                by_reg    <= WW'(norm_d);
                ax_reg    <= mag;
                bx_reg    <= WW'(mag);
                yacc_reg  <= '0;
                xacc_reg  <= '0;
                cnt_reg   <= '0;
                score_reg <= '0;
            end
            SC_MUL: begin
                if (ay_reg[0]) begin
                    yacc_reg <= yacc_reg + by_reg;
                end
                if (ax_reg[0]) begin
                    xacc_reg <= xacc_reg + bx_reg;
                end
                ay_reg  <= ay_reg >> 1;
                ax_reg  <= ax_reg >> 1;
                by_reg  <= by_reg << 1;
                bx_reg  <= bx_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            SC_PREP: begin
                yb_reg  <= yacc_reg << 30;
                p_reg   <= '0;
                r_reg   <= '0;
                m_reg   <= '0;
                cnt_reg <= '0;
            end
            SC_SRCH: begin
                if (take) begin
                    p_reg <= trial;
                    r_reg <= (r_reg >> 1) + yb_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                yb_reg    <= yb_reg >> 2;
                m_reg     <= m_new;
                cnt_reg   <= cnt_reg + 1'b1;
                score_reg <= score_fin;
            end
            default: begin
            end
        endcase
    end

    assign done  = done_reg;
    assign score = score_reg;

endmodule

[design/ctk_cell.sv]
// One cell of the sorted top-k chain: holds one score and index.
// Depends on ctk_pkg; inserts a broadcast candidate or shifts toward the output.
`timescale 1ns / 1ps

module ctk_cell import ctk_pkg::*; #(
    parameter int INDEX_W = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ctk_cell_ctrl_t            ctrl,
    input  logic signed [SCORE_W-1:0] cand_score,
    input  logic        [INDEX_W-1:0] cand_index,
    input  logic                      prev_valid,
    input  logic signed [SCORE_W-1:0] prev_score,
    input  logic        [INDEX_W-1:0] prev_index,
    input  logic                      prev_beat,
    input  logic                      next_valid,
    input  logic signed [SCORE_W-1:0] next_score,
    input  logic        [INDEX_W-1:0] next_index,
    output logic                      valid,
    output logic signed [SCORE_W-1:0] score,
    output logic        [INDEX_W-1:0] index,
    output logic                      beat
);

    logic                      valid_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic        [INDEX_W-1:0] index_reg;

    assign beat = !valid_reg || (cand_score > score_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctrl.insert) begin
            if (prev_beat) begin
                valid_reg <= prev_valid;
            end else if (beat) begin
                valid_reg <= 1'b1;
            end
        end else if (ctrl.shift) begin
            valid_reg <= next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.insert) begin
            if (prev_beat) begin
                score_reg <= prev_score;
                index_reg <= prev_index;
            end else if (beat) begin
                score_reg <= cand_score;
                index_reg <= cand_index;
            end
        end else if (ctrl.shift) begin
            score_reg <= next_score;
            index_reg <= next_index;
        end
    end

    assign valid = valid_reg;
    assign score = score_reg;
    assign index = index_reg;

endmodule

[design/cosine_topk_vector_search.sv]
// Top level of the cosine top-k vector search: intake, memories, dot pass, output.
// Depends on ctk_pkg, ctk_score, ctk_cell and assert_macros.svh.
//
// Usage: elements stream in on the s_ channel, one per transfer, s_cmd 0 for a
// stored vector and 1 for a query. After dim_in_use elements an add reports
// its index (or store full) on the m_ channel in the cycle after the transfer.
// A query's last element starts a search pass; during it s_ready is low.
// Per stored vector the pass forms the dot product through the single vector
// memory read port, then scores it in the iterative score unit; it then emits
// min(top_k, stored count) matches, one per cycle while the receiver is ready,
// best first, m_last on the final one. An empty store gives one empty status.
// Non-final elements give no result, taken one per cycle while s_ready is high.
// Configuration writes on the cfg_ channel are always ready; the user must make
// them only while the block is idle, not enforced by the block. Reset empties
// the store and restores top_k 4 and dim_in_use 64; memories are not cleared.
// A stalled receiver holds the output register and pauses intake or emission.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cosine_topk_vector_search import ctk_pkg::*; #(
    parameter int MAX_DOCS  = 256,
    parameter int DIM_MAX   = 64,
    parameter int K_MAX     = 16,
    parameter int ELEM_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic signed [ELEM_BITS-1:0]          s_element,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic        [1:0]                    m_status,
    output logic        [$clog2(MAX_DOCS)-1:0]   m_doc_index,
    output logic signed [SCORE_W-1:0]            m_score,
    output logic                                 m_last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [CFG_IDX_W-1:0]          cfg_index,
    input  logic        [CFG_DATA_W-1:0]         cfg_data
);

    localparam int E     = ELEM_BITS;
    localparam int DOCW  = $clog2(MAX_DOCS);
    localparam int CNTW  = $clog2(MAX_DOCS + 1);
    localparam int IW    = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int DIMW  = $clog2(DIM_MAX + 1);
    localparam int KW    = $clog2(K_MAX + 1);
    localparam int NW    = 2 * E + $clog2(DIM_MAX);
    localparam int DW    = NW + 1;
    localparam int ADDRW = DOCW + IW;

    ctk_state_t state_reg, state_next;

    logic [4:0]      top_k_reg;
    logic [6:0]      dim_reg;
    logic [CNTW-1:0] doc_count_reg;
    logic [IW-1:0]   pos_reg;
    logic            cur_kind_reg;
    logic [NW-1:0]   add_acc_reg, q_acc_reg;

    logic [DOCW-1:0] d_reg;
    logic [IW-1:0]   i_reg;
    logic            issuing_reg, p1_reg, p1_last_reg, p2_reg, p2_last_reg;
    logic signed [E-1:0]    vm_rd_reg, qb_rd_reg;
    logic signed [2*E-1:0]  prod_reg;
    logic signed [DW-1:0]   dot_acc_reg, dot_reg;
    logic [NW-1:0]   nd_rd_reg;
    logic            sc_start_reg;
    logic [KW-1:0]   emit_left_reg;

    logic                      m_valid_reg;
    ctk_status_t               m_status_reg;
    logic [DOCW-1:0]           m_index_reg;
    logic signed [SCORE_W-1:0] m_score_reg;
    logic                      m_last_reg;

    logic signed [E-1:0] vmem [2**ADDRW];
    logic signed [E-1:0] qbuf [2**IW];
    logic [NW-1:0]       nmem [MAX_DOCS];

    logic [DIMW-1:0] dim_eff;
    logic [KW-1:0]   k_eff, n_emit;
    logic            s_fire, out_free, kind_switch, vec_done, store_full;
    logic [IW-1:0]   pos;
    logic [NW-1:0]   add_base, q_base, sq, add_sum, q_sum;
    logic signed [2*E-1:0] sq_full;
    logic            issue_last, dot_done, pass_done;

    logic                      sc_done;
    logic signed [SCORE_W-1:0] sc_score;
    ctk_cell_ctrl_t            cell_ctrl;

    logic                      c_valid [K_MAX];
    logic signed [SCORE_W-1:0] c_score [K_MAX];
    logic        [DOCW-1:0]    c_index [K_MAX];
    logic                      c_beat  [K_MAX];

    always_comb begin
        if (dim_reg == '0) begin
            dim_eff = DIMW'(1);
        end else if (int'(dim_reg) > DIM_MAX) begin
            dim_eff = DIMW'(DIM_MAX);
        end else begin
            dim_eff = DIMW'(dim_reg);
        end
        if (top_k_reg == '0) begin
            k_eff = KW'(1);
        end else if (int'(top_k_reg) > K_MAX) begin
            k_eff = KW'(K_MAX);
        end else begin
            k_eff = KW'(top_k_reg);
        end
        if (int'(k_eff) < int'(doc_count_reg)) begin
            n_emit = k_eff;
        end else begin
            n_emit = KW'(doc_count_reg);
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        kind_switch = (pos_reg != '0) && (s_cmd != cur_kind_reg);
        pos         = kind_switch ? '0 : pos_reg;
        add_base    = kind_switch ? '0 : add_acc_reg;
        q_base      = kind_switch ? '0 : q_acc_reg;
        sq_full     = s_element * s_element;
        sq          = NW'($unsigned(sq_full));
        add_sum     = add_base + sq;
        q_sum       = q_base + sq;
        vec_done    = !((DIMW'(pos) + DIMW'(1)) < dim_eff);
        store_full  = !(doc_count_reg < CNTW'(MAX_DOCS));
        issue_last  = (DIMW'(i_reg) + DIMW'(1)) == dim_eff;
        dot_done    = p2_reg && p2_last_reg;
        pass_done   = DOCW'(doc_count_reg - 1'b1) == d_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_cmd == CMD_QUERY && vec_done && doc_count_reg != '0) begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT: begin
                if (dot_done) begin
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE: begin
                if (sc_done) begin
                    state_next = pass_done ? ST_EMIT : ST_DOT;
                end
            end
            ST_EMIT: begin
                if (out_free && emit_left_reg == KW'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cell_ctrl.clear  = (state_reg == ST_IDLE) && (state_next == ST_DOT);
        cell_ctrl.insert = (state_reg == ST_SCORE) && sc_done;
        cell_ctrl.shift  = (state_reg == ST_EMIT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_k_reg     <= 5'd4;
            dim_reg       <= 7'd64;
            doc_count_reg <= '0;
            pos_reg       <= '0;
            cur_kind_reg  <= CMD_ADD;
            add_acc_reg   <= '0;
            q_acc_reg     <= '0;
            issuing_reg   <= 1'b0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            sc_start_reg  <= 1'b0;
            emit_left_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_TOP_K) begin
                    top_k_reg <= cfg_data[4:0];
                end else if (cfg_index == CFG_DIM) begin
                    dim_reg <= cfg_data[6:0];
                end
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            sc_start_reg <= (state_reg == ST_DOT) && dot_done;

            if (s_fire) begin
                cur_kind_reg <= s_cmd;
                pos_reg      <= vec_done ? '0 : pos + 1'b1;
                if (s_cmd == CMD_ADD) begin
                    add_acc_reg <= vec_done ? '0 : add_sum;
                    q_acc_reg   <= q_base;
                    if (vec_done) begin
                        m_valid_reg <= 1'b1;
                        if (!store_full) begin
                            doc_count_reg <= doc_count_reg + 1'b1;
                        end
                    end
                end else begin
                    add_acc_reg <= add_base;
                    if (vec_done && doc_count_reg == '0) begin
                        q_acc_reg   <= '0;
                        m_valid_reg <= 1'b1;
                    end else begin
                        q_acc_reg <= q_sum;
                    end
                end
            end

            if (state_next == ST_DOT && state_reg != ST_DOT) begin
                issuing_reg <= 1'b1;
            end else if (state_reg == ST_DOT && issuing_reg && issue_last) begin
                issuing_reg <= 1'b0;
            end
            p1_reg <= (state_reg == ST_DOT) && issuing_reg;
            p2_reg <= (state_reg == ST_DOT) && p1_reg;

            if (state_reg == ST_SCORE && sc_done && pass_done) begin
                emit_left_reg <= n_emit;
                q_acc_reg     <= '0;
            end
            if (state_reg == ST_EMIT && out_free) begin
                emit_left_reg <= emit_left_reg - 1'b1;
                m_valid_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (s_cmd == CMD_ADD) begin
                m_status_reg <= store_full ? STATUS_FULL : STATUS_ADDED;
                m_index_reg  <= store_full ? '0 : DOCW'(doc_count_reg);
            end else begin
                m_status_reg <= STATUS_EMPTY;
                m_index_reg  <= '0;
            end
            m_score_reg <= '0;
            m_last_reg  <= 1'b1;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_status_reg <= STATUS_MATCH;
            m_index_reg  <= c_index[0];
            m_score_reg  <= c_score[0];
            m_last_reg   <= (emit_left_reg == KW'(1));
        end

        if (state_next == ST_DOT && state_reg != ST_DOT) begin
            i_reg       <= '0;
            dot_acc_reg <= '0;
            d_reg       <= (state_reg == ST_IDLE) ? '0 : d_reg + 1'b1;
        end else if (state_reg == ST_DOT) begin
            if (issuing_reg) begin
                i_reg <= i_reg + 1'b1;
            end
            if (p2_reg) begin
                dot_acc_reg <= dot_acc_reg + DW'(prod_reg);
            end
        end
        p1_last_reg <= issue_last;
        p2_last_reg <= p1_last_reg;
        prod_reg    <= vm_rd_reg * qb_rd_reg;
        if (dot_done) begin
            dot_reg <= dot_acc_reg + DW'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_cmd == CMD_ADD && !store_full) begin
            vmem[{DOCW'(doc_count_reg), pos}] <= s_element;
        end
        vm_rd_reg <= vmem[{d_reg, i_reg}];
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_cmd == CMD_QUERY) begin
            qbuf[pos] <= s_element;
        end
        qb_rd_reg <= qbuf[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_cmd == CMD_ADD && vec_done && !store_full) begin
            nmem[DOCW'(doc_count_reg)] <= add_sum;
        end
        nd_rd_reg <= nmem[d_reg];
    end

    ctk_score #(
        .DW (DW),
        .NW (NW)
    ) u_score (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sc_start_reg),
        .dot     (dot_reg),
        .norm_q  (q_acc_reg),
        .norm_d  (nd_rd_reg),
        .done    (sc_done),
        .score   (sc_score)
    );

    for (genvar g = 0; g < K_MAX; g++) begin : g_cell
        logic                      pv, nv, pb;
        logic signed [SCORE_W-1:0] ps, ns;
        logic        [DOCW-1:0]    pi, ni;
        if (g == 0) begin : g_head
            assign pv = 1'b0;
            assign ps = '0;
            assign pi = '0;
            assign pb = 1'b0;
        end else begin : g_body
            assign pv = c_valid[g-1];
            assign ps = c_score[g-1];
            assign pi = c_index[g-1];
            assign pb = c_beat[g-1];
        end
        if (g == K_MAX - 1) begin : g_tail
            assign nv = 1'b0;
            assign ns = '0;
            assign ni = '0;
        end else begin : g_link
            assign nv = c_valid[g+1];
            assign ns = c_score[g+1];
            assign ni = c_index[g+1];
        end
        ctk_cell #(
            .INDEX_W (DOCW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .cand_score (sc_score),
            .cand_index (d_reg),
            .prev_valid (pv),
            .prev_score (ps),
            .prev_index (pi),
            .prev_beat  (pb),
            .next_valid (nv),
            .next_score (ns),
            .next_index (ni),
            .valid      (c_valid[g]),
            .score      (c_score[g]),
            .index      (c_index[g]),
            .beat       (c_beat[g])
        );
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_doc_index = m_index_reg;
    assign m_score     = m_score_reg;
    assign m_last      = m_last_reg;

    `CTK_ASSERT(a_emit_has_work, aclk, aresetn, (state_reg != ST_EMIT) || (emit_left_reg != '0))
    `CTK_ASSERT(a_score_done_in_pass, aclk, aresetn, !sc_done || (state_reg == ST_SCORE))
    `CTK_ASSERT_NEXT(a_add_counts, aclk, aresetn, s_fire && (s_cmd == CMD_ADD) && vec_done && !store_full, doc_count_reg == $past(doc_count_reg) + 1'b1)

endmodule
